// ===== design/sog_pkg.sv =====
// Package for the sprite outline generator: payload structs, register codes,
// controller/datapath command and status structs, and divide-by-255 helper.
// No dependencies.
`default_nettype none
package sog_pkg;

    localparam int DEF_CELL_W = 64;
    localparam int DEF_CELL_H = 64;
    localparam int DEF_REACH  = 7;

    typedef enum logic [2:0] {
        REG_CELL_W  = 3'd0,
        REG_CELL_H  = 3'd1,
        REG_MARGIN  = 3'd2,
        REG_REACH   = 3'd3,
        REG_OUTLINE = 3'd4,
        REG_FILL    = 3'd5
    } reg_index_t;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } opcode_t;

    typedef struct packed {
        logic       opcode;
        logic [6:0] col;
        logic [6:0] row;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic [7:0] alpha_in;
    } request_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic [7:0] alpha_out;
    } result_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic setup;     // latch the request and work out the window
        logic write;     // write a source pixel
        logic read_win;  // issue a read at the window position
        logic acc;       // add the alpha of last cycle's read
        logic step;      // advance the window position
        logic read_ctr;  // issue a read at the centre pixel
        logic calc;      // register products of the blend
        logic finish;    // divide and form the result
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_query;
        logic in_store;
        logic in_grown;
        logic win_empty;
        logic win_last;
    } status_t;

    // Exact floor(v / 255) for v < 512 * 255 by reciprocal and one correction.
    function automatic logic [8:0] div255(input logic [16:0] v);
        logic [25:0] p;
        logic [8:0]  q;
        logic [16:0] r;
        begin
            p = 26'(v) * 26'd257;
            q = p[24:16];
            r = v - 17'(q) * 17'd255;
            if (r >= 17'd255)
            begin
                q = q + 9'd1;
            end
            div255 = q;
        end
    endfunction

endpackage
`default_nettype wire

// ===== design/sog_ctrl.sv =====
// Controller state machine for the sprite outline generator.
// Depends on sog_pkg.
`default_nettype none
module sog_ctrl
    import sog_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    output logic      busy,
    output cmd_t      cmd,
    input  status_t   stat
);

    typedef enum logic [2:0] {
        S_IDLE, S_SETUP, S_SUM, S_DRAIN, S_CTR, S_WAIT, S_CALC, S_DONE
    } state_t;

    state_t state_reg;

    // Commands decode from the present state.
    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            S_IDLE:  cmd.setup = start;
            S_SETUP:
            begin
                cmd.write    = !stat.is_query && stat.in_store;
            end
            S_SUM:
            begin
                cmd.acc      = 1'b1;
                cmd.step     = 1'b1;
                cmd.read_win = 1'b1;
            end
            S_DRAIN: cmd.acc = 1'b1;
            S_CTR:   cmd.read_ctr = 1'b1;
            S_WAIT:  ;
            S_CALC:  cmd.calc = 1'b1;
            S_DONE:  cmd.finish = 1'b1;
            default: ;
        endcase
    end

    assign busy = (state_reg != S_IDLE);

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:  if (start) state_reg <= S_SETUP;
                S_SETUP:
                begin
                    if (!stat.is_query)
                        state_reg <= S_IDLE;
                    else if (!stat.in_grown)
                        state_reg <= S_DONE;
                    else if (stat.win_empty)
                        state_reg <= S_CTR;
                    else
                        state_reg <= S_SUM;
                end
                S_SUM:   if (stat.win_last) state_reg <= S_DRAIN;
                S_DRAIN: state_reg <= S_CTR;
                S_CTR:   state_reg <= S_WAIT;
                S_WAIT:  state_reg <= S_CALC;
                S_CALC:  state_reg <= S_DONE;
                S_DONE:  state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== design/sog_datapath.sv =====
// Datapath for the sprite outline generator: config registers, cell memory,
// window walker, alpha accumulator and blend. Depends on sog_pkg.
`default_nettype none
module sog_datapath
    import sog_pkg::*;
#(
    parameter int MAX_CELL_W = DEF_CELL_W,
    parameter int MAX_CELL_H = DEF_CELL_H,
    parameter int MAX_REACH  = DEF_REACH
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  request_t   req,
    input  wire logic  cfg_valid,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  cmd_t       cmd,
    output status_t    stat,
    output logic       result_valid,
    output result_t    result
);

    localparam int DEPTH = MAX_CELL_W * MAX_CELL_H;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    // Sum of up to 15x15 alphas of 255 fits in 18 bits.
    localparam int SW    = 18;

    // Configuration registers.
    logic [6:0]  cell_w_reg, cell_h_reg;
    logic [3:0]  margin_reg;
    logic [2:0]  reach_reg;
    logic [31:0] outline_reg, fill_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_w_reg  <= 7'd64;
            cell_h_reg  <= 7'd64;
            margin_reg  <= 4'd1;
            reach_reg   <= 3'd1;
            outline_reg <= 32'hFF00_0000;
            fill_reg    <= 32'd0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_CELL_W:  cell_w_reg  <= cfg_data[6:0];
                REG_CELL_H:  cell_h_reg  <= cfg_data[6:0];
                REG_MARGIN:  margin_reg  <= cfg_data[3:0];
                REG_REACH:   reach_reg   <= cfg_data[2:0];
                REG_OUTLINE: outline_reg <= cfg_data;
                REG_FILL:    fill_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // Effective sizes, clamped to the store; the reach is clamped to MAX_REACH.
    logic [8:0] w_eff, h_eff, r_eff;
    assign w_eff = (9'(cell_w_reg) > 9'(MAX_CELL_W)) ? 9'(MAX_CELL_W) : 9'(cell_w_reg);
    assign h_eff = (9'(cell_h_reg) > 9'(MAX_CELL_H)) ? 9'(MAX_CELL_H) : 9'(cell_h_reg);
    assign r_eff = (9'(reach_reg) > 9'(MAX_REACH)) ? 9'(MAX_REACH) : 9'(reach_reg);

    // Signed window bounds for the incoming request.
    logic signed [10:0] xc, yc, xmin, ymin, xmax, ymax;
    always_comb
    begin
        xc   = 11'(req.col) - 11'(margin_reg);
        yc   = 11'(req.row) - 11'(margin_reg);
        xmin = xc - 11'(r_eff);
        ymin = yc - 11'(r_eff);
        xmax = xc + 11'(r_eff) + 11'sd1;
        ymax = yc + 11'(r_eff) + 11'sd1;
        if (xmin < 0) xmin = '0;
        if (ymin < 0) ymin = '0;
        if (xmax > $signed(11'(w_eff))) xmax = 11'(w_eff);
        if (ymax > $signed(11'(h_eff))) ymax = 11'(h_eff);
    end

    // Latched request and window.
    request_t    req_reg;
    logic [8:0]  x0_reg, y0_reg, x1_reg, y1_reg, xi_reg, yj_reg;
    logic        in_grown_reg, win_empty_reg, centre_reg;
    logic [8:0]  cx_reg, cy_reg;
    logic [SW-1:0] sum_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.setup)
        begin
            req_reg       <= req;
            x0_reg        <= 9'(xmin);
            y0_reg        <= 9'(ymin);
            x1_reg        <= 9'(xmax - 11'sd1);
            y1_reg        <= 9'(ymax - 11'sd1);
            xi_reg        <= 9'(xmin);
            yj_reg        <= 9'(ymin);
            in_grown_reg  <= (10'(req.col) < 10'(w_eff) + 10'(margin_reg) * 10'd2)
                          && (10'(req.row) < 10'(h_eff) + 10'(margin_reg) * 10'd2);
            win_empty_reg <= (xmin >= xmax) || (ymin >= ymax);
            centre_reg    <= (xc >= 0) && (yc >= 0)
                          && (xc < $signed(11'(w_eff))) && (yc < $signed(11'(h_eff)));
            cx_reg        <= 9'(xc);
            cy_reg        <= 9'(yc);
        end
        else if (cmd.step)
        begin
            if (yj_reg == y1_reg)
            begin
                yj_reg <= y0_reg;
                xi_reg <= xi_reg + 9'd1;
            end
            else
            begin
                yj_reg <= yj_reg + 9'd1;
            end
        end
    end

    assign stat.is_query  = (req_reg.opcode == OP_QUERY);
    assign stat.in_store  = (9'(req_reg.col) < 9'(MAX_CELL_W))
                         && (9'(req_reg.row) < 9'(MAX_CELL_H));
    assign stat.in_grown  = in_grown_reg;
    assign stat.win_empty = win_empty_reg;
    assign stat.win_last  = (xi_reg == x1_reg) && (yj_reg == y1_reg);

    // Cell memory, one write or one read per cycle, read data registered.
    logic [31:0] mem [DEPTH];
    logic [31:0] rd_reg;
    logic        win_rd_reg;
    logic [AW-1:0] waddr, raddr;
    logic [8:0]  rx, ry;

    assign waddr = AW'(req_reg.row) * AW'(MAX_CELL_W) + AW'(req_reg.col);
    assign rx    = cmd.read_ctr ? cx_reg : xi_reg;
    assign ry    = cmd.read_ctr ? cy_reg : yj_reg;
    assign raddr = AW'(ry) * AW'(MAX_CELL_W) + AW'(rx);

    // The read data holds until the next read; win_rd_reg marks window data.
    always_ff @(posedge clk)
    begin
        if (cmd.write)
        begin
            mem[waddr] <= {req_reg.alpha_in, req_reg.blue_in, req_reg.green_in, req_reg.red_in};
        end
        if (cmd.read_win || cmd.read_ctr)
        begin
            rd_reg <= mem[raddr];
        end
        win_rd_reg <= cmd.read_win;
    end

    // Alpha accumulator, fed only by window reads.
    always_ff @(posedge clk)
    begin
        if (cmd.setup)
            sum_reg <= '0;
        else if (cmd.acc && win_rd_reg)
            sum_reg <= sum_reg + SW'(rd_reg[31:24]);
    end

    // Blend products, registered before the divide.
    logic [7:0]  base_a;
    logic [7:0]  base_a_reg;
    logic [31:0] pick;
    logic [7:0]  sa, inv;
    logic        has_sum;
    logic [16:0] prod_reg [4];
    logic [16:0] prod_base_a_reg;
    logic        blend_reg, has_sum_reg;

    assign has_sum = (sum_reg != '0);
    assign base_a  = 8'(div255(17'((sum_reg > SW'(255)) ? 8'd255 : sum_reg[7:0])
                     * 17'(outline_reg[31:24])));
    assign sa      = rd_reg[31:24];
    assign inv     = 8'd255 - sa;
    assign pick    = (fill_reg[31:24] == 8'd0 && fill_reg[7:0] != 8'd0) ? rd_reg : fill_reg;

    // Outline alpha is registered while the centre pixel is read.
    always_ff @(posedge clk)
    begin
        base_a_reg <= base_a;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.calc)
        begin
            has_sum_reg     <= has_sum;
            blend_reg       <= centre_reg && (sa != 8'd0);
            prod_base_a_reg <= has_sum ? 17'(base_a_reg) : 17'd0;
            for (int k = 0; k < 3; k++)
            begin
                prod_reg[k] <= (has_sum ? 17'(outline_reg[8*k +: 8]) : 17'd0) * 17'(inv)
                             + 17'(pick[8*k +: 8]) * 17'(sa);
            end
            prod_reg[3] <= 17'(8'd255 - (has_sum ? base_a_reg : 8'd0)) * 17'(inv);
        end
    end

    // Final divide and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid <= 1'b0;
        end
        else
        begin
            result_valid <= cmd.finish;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            if (!in_grown_reg)
            begin
                result <= '0;
            end
            else if (blend_reg)
            begin
                result.red_out   <= 8'(div255(prod_reg[0]));
                result.green_out <= 8'(div255(prod_reg[1]));
                result.blue_out  <= 8'(div255(prod_reg[2]));
                result.alpha_out <= 8'd255 - 8'(div255(prod_reg[3]));
            end
            else
            begin
                result.red_out   <= has_sum_reg ? outline_reg[7:0] : 8'd0;
                result.green_out <= has_sum_reg ? outline_reg[15:8] : 8'd0;
                result.blue_out  <= has_sum_reg ? outline_reg[23:16] : 8'd0;
                result.alpha_out <= 8'(prod_base_a_reg);
            end
        end
    end

endmodule
`default_nettype wire

// ===== design/sprite_outline_generator_top.sv =====
// Top level of the sprite outline generator: controller plus datapath.
// Depends on sog_pkg, sog_ctrl and sog_datapath.
//
// Usage. A request is taken when start is high and busy is low. A load
// (opcode 0) writes one RGBA pixel into the cell memory when in the store.
// A query (opcode 1) returns one pixel on result, marked by result_valid
// for exactly one cycle. A query walks its alpha window one memory read per
// cycle through the single memory port, where the clipped window holds at
// most 15 by 15 source pixels; an empty window skips the walk and a query
// outside the grown cell returns zeros without it. The next request can be
// taken at the edge that ends the result cycle. Results cannot be held off.
// Configuration writes go through cfg_valid/cfg_ready with cfg_index and
// cfg_data; cfg_ready is always high. The user must make writes only while
// idle; the block itself does not enforce this.
// Reset returns the registers to their defaults; the cell memory is not
// cleared and every pixel must be loaded before it is queried.
`default_nettype none
module sprite_outline_generator_top
    import sog_pkg::*;
#(
    parameter int MAX_CELL_W = DEF_CELL_W,
    parameter int MAX_CELL_H = DEF_CELL_H,
    parameter int MAX_REACH  = DEF_REACH
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  request_t         request,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    output logic             result_valid,
    output result_t          result
);

    cmd_t    cmd;
    status_t stat;

    assign cfg_ready = 1'b1;

    sog_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .stat  (stat)
    );

    sog_datapath #(
        .MAX_CELL_W (MAX_CELL_W),
        .MAX_CELL_H (MAX_CELL_H),
        .MAX_REACH  (MAX_REACH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (request),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .stat         (stat),
        .result_valid (result_valid),
        .result       (result)
    );

    // A result only ever appears while a request is being worked on.
    a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result without an active request");

    // A result strobe lasts one cycle.
    a_result_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe longer than one cycle");

    // A new request is never taken while one is in flight.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy did not rise after a request");

endmodule
`default_nettype wire

// ===== tb/sv/tb_sprite_outline_generator_top.sv =====
// Testbench for the sprite outline generator top level: loads a cell, queries
// outlined pixels under many register settings, and checks every result.
// Depends on sog_pkg and sprite_outline_generator_top.
`default_nettype none
module tb_sprite_outline_generator_top;
    import sog_pkg::*;

    localparam int STORE_W       = 64;
    localparam int STORE_H       = 64;
    localparam int FILL_W        = 16;
    localparam int FILL_H        = 16;
    localparam int WATCHDOG_MAX  = 4000;
    localparam logic [2:0] UNUSED_REG = 3'd7;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    request_t    request;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        result_valid;
    result_t     result;

    // Mirror of the block's registers and cell memory.
    logic [6:0]  cell_w_q;
    logic [6:0]  cell_h_q;
    logic [3:0]  margin_q;
    logic [2:0]  reach_q;
    logic [31:0] outline_q;
    logic [31:0] fill_q;
    logic [31:0] pixel_mem [0:STORE_W*STORE_H-1];
    bit          written_q [0:STORE_W*STORE_H-1];

    result_t     pixel_q [$];
    int          mismatches;
    int          loads_sent;
    int          queries_sent;
    int          results_seen;
    int          idle_cycles;
    bit          gaps_on;
    bit          timed_out;

    sprite_outline_generator_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result       (result)
    );

    // Clock with a period of 12.
    initial
    begin
        clk = 1'b0;
    end
    always #6 clk = ~clk;

    function automatic int chan(input logic [31:0] px, input int k);
        return int'((px >> (8 * k)) & 32'hFF);
    endfunction

    // Expected output pixel at grown coordinates (x, y).
    function automatic result_t outline_pixel(input int x, input int y);
        int      w, h, m, r, x0, x1, y0, y1, sum, sa, inv;
        int      c [4];
        logic [31:0] src, pick;
        result_t res;
        begin
            w = (cell_w_q > STORE_W) ? STORE_W : int'(cell_w_q);
            h = (cell_h_q > STORE_H) ? STORE_H : int'(cell_h_q);
            m = int'(margin_q);
            r = int'(reach_q);
            sum = 0;
            for (int k = 0; k < 4; k++)
            begin
                c[k] = 0;
            end
            if (x < w + 2 * m && y < h + 2 * m)
            begin
                x0 = (x - m - r < 0) ? 0 : x - m - r;
                y0 = (y - m - r < 0) ? 0 : y - m - r;
                x1 = (x - m + 1 + r > w) ? w : x - m + 1 + r;
                y1 = (y - m + 1 + r > h) ? h : y - m + 1 + r;
                for (int i = x0; i < x1; i++)
                begin
                    for (int j = y0; j < y1; j++)
                    begin
                        sum += chan(pixel_mem[j * STORE_W + i], 3);
                    end
                end
                if (sum > 0)
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        c[k] = chan(outline_q, k);
                    end
                    c[3] = ((sum > 255) ? 255 : sum) * chan(outline_q, 3) / 255;
                end
                // Blend the fill or source colour where the source pixel shows.
                if (x >= m && x < m + w && y >= m && y < m + h)
                begin
                    src = pixel_mem[(y - m) * STORE_W + (x - m)];
                    sa = chan(src, 3);
                    if (sa > 0)
                    begin
                        inv = 255 - sa;
                        pick = (chan(fill_q, 3) == 0 && chan(fill_q, 0) > 0) ? src : fill_q;
                        for (int k = 0; k < 3; k++)
                        begin
                            c[k] = (c[k] * inv + chan(pick, k) * sa) / 255;
                        end
                        c[3] = 255 - (255 - c[3]) * inv / 255;
                    end
                end
            end
            res.red_out   = c[0][7:0];
            res.green_out = c[1][7:0];
            res.blue_out  = c[2][7:0];
            res.alpha_out = c[3][7:0];
            return res;
        end
    endfunction

    // True when every pixel that a query at (x, y) reads has been loaded.
    function automatic bit query_ok(input int x, input int y);
        int w, h, m, r, x0, x1, y0, y1;
        begin
            w = (cell_w_q > STORE_W) ? STORE_W : int'(cell_w_q);
            h = (cell_h_q > STORE_H) ? STORE_H : int'(cell_h_q);
            m = int'(margin_q);
            r = int'(reach_q);
            if (x >= w + 2 * m || y >= h + 2 * m)
                return 1'b1;
            x0 = (x - m - r < 0) ? 0 : x - m - r;
            y0 = (y - m - r < 0) ? 0 : y - m - r;
            x1 = (x - m + 1 + r > w) ? w : x - m + 1 + r;
            y1 = (y - m + 1 + r > h) ? h : y - m + 1 + r;
            for (int i = x0; i < x1; i++)
            begin
                for (int j = y0; j < y1; j++)
                begin
                    if (!written_q[j * STORE_W + i])
                        return 1'b0;
                end
            end
            return 1'b1;
        end
    endfunction

    task automatic report(input string what, input int got, input int want);
        begin
            $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
            mismatches++;
        end
    endtask

    // Send one request and update the mirror once it is taken. Start stays
    // high on return unless a random gap lowered it; drain lowers it at the end.
    task automatic send_request(input request_t req);
        begin
            start   <= 1'b1;
            request <= req;
            do
            begin
                @(posedge clk);
            end
            while (busy);
            if (req.opcode == OP_LOAD)
            begin
                loads_sent++;
                if (req.col < STORE_W && req.row < STORE_H)
                begin
                    pixel_mem[req.row * STORE_W + req.col] =
                        {req.alpha_in, req.blue_in, req.green_in, req.red_in};
                    written_q[req.row * STORE_W + req.col] = 1'b1;
                end
            end
            else
            begin
                queries_sent++;
                pixel_q = {pixel_q, outline_pixel(req.col, req.row)};
            end
            if (gaps_on && $urandom_range(0, 3) == 0)
            begin
                start <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
        end
    endtask

    task automatic send_load(input int x, input int y, input logic [31:0] px);
        request_t req;
        begin
            req = '{opcode: OP_LOAD, col: x[6:0], row: y[6:0], red_in: px[7:0],
                    green_in: px[15:8], blue_in: px[23:16], alpha_in: px[31:24]};
            send_request(req);
        end
    endtask

    task automatic send_query(input int x, input int y);
        request_t req;
        begin
            req.opcode   = OP_QUERY;
            req.col      = x[6:0];
            req.row      = y[6:0];
            req.red_in   = 8'($urandom);
            req.green_in = 8'($urandom);
            req.blue_in  = 8'($urandom);
            req.alpha_in = 8'($urandom);
            send_request(req);
        end
    endtask

    // Random query that only reads loaded pixels; falls back to a far corner.
    task automatic send_safe_query(input int lim_x, input int lim_y);
        int x, y;
        begin
            x = $urandom_range(0, lim_x);
            y = $urandom_range(0, lim_y);
            for (int t = 0; t < 16 && !query_ok(x, y); t++)
            begin
                x = $urandom_range(0, lim_x);
                y = $urandom_range(0, lim_y);
            end
            if (!query_ok(x, y))
            begin
                x = 127;
                y = 127;
            end
            send_query(x, y);
        end
    endtask

    // Let every pending request finish, including a trailing load.
    task automatic drain;
        begin
            start <= 1'b0;
            do
            begin
                @(posedge clk);
            end
            while (busy || pixel_q.size() != 0);
            repeat (8) @(posedge clk);
        end
    endtask

    // Write one register; cfg_valid is lowered by the caller.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= data;
            do
            begin
                @(posedge clk);
            end
            while (!cfg_ready);
            case (idx)
                REG_CELL_W:  cell_w_q  = data[6:0];
                REG_CELL_H:  cell_h_q  = data[6:0];
                REG_MARGIN:  margin_q  = data[3:0];
                REG_REACH:   reach_q   = data[2:0];
                REG_OUTLINE: outline_q = data;
                REG_FILL:    fill_q    = data;
                default: ;
            endcase
        end
    endtask

    task automatic configure(input int w, input int h, input int m, input int r,
                             input logic [31:0] outline, input logic [31:0] fill);
        begin
            write_reg(REG_CELL_W, w);
            write_reg(REG_CELL_H, h);
            write_reg(REG_MARGIN, m);
            write_reg(REG_REACH, r);
            write_reg(REG_OUTLINE, outline);
            write_reg(REG_FILL, fill);
            cfg_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    function automatic logic [31:0] random_pixel();
        logic [31:0] px;
        begin
            px = $urandom;
            case ($urandom_range(0, 3))
                0: px[31:24] = 8'd0;
                1: px[31:24] = 8'd255;
                default: ;
            endcase
            return px;
        end
    endfunction

    // Load the top-left corner of the memory; queries only reach loaded pixels.
    task automatic test_fill_memory;
        begin
            for (int y = 0; y < FILL_H; y++)
            begin
                for (int x = 0; x < FILL_W; x++)
                begin
                    send_load(x, y, random_pixel());
                end
            end
            drain();
        end
    endtask

    // Queries under the reset register values.
    task automatic test_reset_defaults;
        begin
            send_load(63, 63, random_pixel());
            send_query(0, 0);
            send_query(10, 12);
            send_query(65, 65);
            send_query(66, 3);
            drain();
        end
    endtask

    // Field extremes, special register values and the ignored index.
    task automatic test_directed_extremes;
        begin
            configure(64, 64, 15, 7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
            write_reg(UNUSED_REG, 32'h0000_0001);
            cfg_valid <= 1'b0;
            send_load(127, 127, 32'hFFFF_FFFF);
            send_load(0, 0, 32'hFF00_0000);
            send_load(63, 63, 32'h0000_0000);
            send_query(0, 0);
            send_query(15, 15);
            send_query(93, 93);
            send_query(94, 0);
            send_query(127, 127);
            drain();
            // Oversized cell, no reach, fill that keeps the source colour.
            configure(127, 127, 0, 0, 32'h0000_0000, 32'h0000_0001);
            send_query(0, 0);
            send_query(63, 63);
            send_query(64, 10);
            drain();
            // Zero sized cell gives all zeros.
            configure(0, 5, 3, 2, 32'h80FF_FFFF, 32'h00FF_0000);
            send_query(0, 0);
            send_query(4, 4);
            drain();
            // Single pixel cell.
            configure(1, 1, 1, 1, 32'hFF12_3456, 32'h0000_0000);
            send_query(0, 0);
            send_query(1, 1);
            send_query(2, 2);
            drain();
        end
    endtask

    function automatic int pick_size();
        case ($urandom_range(0, 9))
            0: return 64;
            1: return $urandom_range(65, 127);
            2: return 0;
            default: return $urandom_range(1, 16);
        endcase
    endfunction

    function automatic logic [31:0] pick_fill();
        case ($urandom_range(0, 3))
            0: return {8'd0, 16'($urandom), 8'($urandom_range(1, 255))};
            1: return 32'h0;
            default: return $urandom;
        endcase
    endfunction

    // Random phases: new registers, reloads of the cell, and queries.
    task automatic test_random_phases(input int phases, input int per_phase);
        int w, h, m, lim_x, lim_y;
        begin
            for (int p = 0; p < phases; p++)
            begin
                w = pick_size();
                h = pick_size();
                m = $urandom_range(0, 15);
                configure(w, h, m, $urandom_range(0, 7), $urandom, pick_fill());
                lim_x = ((w > 64) ? 64 : w) + 2 * m + 1;
                lim_y = ((h > 64) ? 64 : h) + 2 * m + 1;
                for (int n = 0; n < per_phase; n++)
                begin
                    case ($urandom_range(0, 9))
                        0: send_safe_query(127, 127);
                        1: send_load($urandom_range(0, 127), $urandom_range(0, 127),
                                     random_pixel());
                        2, 3: send_load($urandom_range(0, (w > 63 || w == 0) ? 63 : w - 1),
                                        $urandom_range(0, (h > 63 || h == 0) ? 63 : h - 1),
                                        random_pixel());
                        default: send_safe_query(lim_x, lim_y);
                    endcase
                end
                drain();
            end
        end
    endtask

    // Compare each result with the oldest expected pixel.
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            results_seen++;
            if (pixel_q.size() == 0)
            begin
                report("unexpected result", 0, 0);
            end
            else
            begin
                result_t want;
                want = pixel_q.pop_front();
                if (result.red_out !== want.red_out)
                    report("red_out", result.red_out, want.red_out);
                if (result.green_out !== want.green_out)
                    report("green_out", result.green_out, want.green_out);
                if (result.blue_out !== want.blue_out)
                    report("blue_out", result.blue_out, want.blue_out);
                if (result.alpha_out !== want.alpha_out)
                    report("alpha_out", result.alpha_out, want.alpha_out);
            end
        end
    end

    // Watchdog on cycles with no request, result or register write taken.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid || (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_MAX && !timed_out)
            begin
                timed_out = 1'b1;
                $display("watchdog expired at %0t", $time);
                $display("tb_sprite_outline_generator_top: FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        request     = '0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        loads_sent  = 0;
        queries_sent = 0;
        gaps_on     = 1'b1;
        cell_w_q    = 7'd64;
        cell_h_q    = 7'd64;
        margin_q    = 4'd1;
        reach_q     = 3'd1;
        outline_q   = 32'hFF00_0000;
        fill_q      = 32'h0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_fill_memory();
        test_reset_defaults();
        test_directed_extremes();
        test_random_phases(10, 40);
        // Closing phases run back to back with no gaps.
        gaps_on = 1'b0;
        test_random_phases(2, 40);

        drain();
        $display("covered %0d loads and %0d queries, %0d results checked",
                 loads_sent, queries_sent, results_seen);
        $display("register settings included zero, oversized and maximum values");
        if (mismatches == 0 && pixel_q.size() == 0)
        begin
            $display("tb_sprite_outline_generator_top: PASS");
        end
        else
        begin
            $display("tb_sprite_outline_generator_top: FAIL");
        end
        $finish;
    end

endmodule
`default_nettype wire
